// ===== rtl/core/path_length_accumulator_top_macros.svh =====
// Assertion macros used by plac_ctrl.
`ifndef PATH_LENGTH_ACCUMULATOR_TOP_MACROS_SVH
`define PATH_LENGTH_ACCUMULATOR_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define PLA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define PLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/plac_pkg.sv =====
package plac_pkg;

	localparam int COORD_BITS = 24;
	localparam int TOTAL_BITS = 40;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int ROOT_STEPS = (SUM_BITS + 1) / 2;
	localparam int ROOT_BITS  = ROOT_STEPS;
	localparam int RAD_BITS   = 2 * ROOT_STEPS;
	localparam int REM_BITS   = ROOT_BITS + 3;
	localparam int SEG_BITS   = COORD_BITS + 1;
	localparam int CNT_BITS   = $clog2(ROOT_STEPS);

	typedef struct packed {
		logic load_in;
		logic sq_x;
		logic sq_y;
		logic load_root;
		logic root_step;
		logic finish;
	} plac_cmd_t;

	typedef struct packed {
		logic root_last;
	} plac_sts_t;

endpackage

// ===== rtl/core/plac_dp.sv =====
module plac_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  plac_pkg::plac_cmd_t                  cmd,
	output plac_pkg::plac_sts_t                  sts,
	input  logic signed [plac_pkg::COORD_BITS-1:0] pos_x,
	input  logic signed [plac_pkg::COORD_BITS-1:0] pos_y,
	output logic [plac_pkg::SEG_BITS-1:0]        segment_length,
	output logic [plac_pkg::TOTAL_BITS-1:0]      total_length,
	output logic                                 total_saturated
);

	logic signed [plac_pkg::COORD_BITS-1:0] last_x_q, last_y_q;
	logic [plac_pkg::TOTAL_BITS-1:0]        total_q;
	logic [plac_pkg::CNT_BITS-1:0]          cnt_q;
	logic [plac_pkg::COORD_BITS-1:0]        ax_q, ay_q;
	logic [plac_pkg::SQ_BITS-1:0]           prod_q;
	logic [plac_pkg::SQ_BITS-1:0]           sqx_q;
	logic [plac_pkg::RAD_BITS-1:0]          rad_q;
	logic [plac_pkg::ROOT_BITS-1:0]         root_q;
	logic [plac_pkg::REM_BITS-1:0]          rem_q;
	logic [plac_pkg::SEG_BITS-1:0]          seg_q;
	logic [plac_pkg::TOTAL_BITS-1:0]        tot_out_q;
	logic                                   sat_q;

	logic signed [plac_pkg::COORD_BITS:0]   dx, dy;
	logic [plac_pkg::COORD_BITS:0]          adx, ady;
	logic [plac_pkg::COORD_BITS-1:0]        mul_a;
	logic [plac_pkg::SUM_BITS-1:0]          sum;
	logic [plac_pkg::REM_BITS-1:0]          rem_sh, trial, rem_n;
	logic                                   ge;
	logic [plac_pkg::TOTAL_BITS:0]          tsum;
	logic [plac_pkg::TOTAL_BITS-1:0]        new_total;

	always_comb begin
		dx  = {pos_x[plac_pkg::COORD_BITS-1], pos_x} - {last_x_q[plac_pkg::COORD_BITS-1], last_x_q};
		dy  = {pos_y[plac_pkg::COORD_BITS-1], pos_y} - {last_y_q[plac_pkg::COORD_BITS-1], last_y_q};
		adx = dx[plac_pkg::COORD_BITS] ? 
			(plac_pkg::COORD_BITS+1)'(-dx) : (plac_pkg::COORD_BITS+1)'(dx);
		ady = dy[plac_pkg::COORD_BITS] ?
			(plac_pkg::COORD_BITS+1)'(-dy) : (plac_pkg::COORD_BITS+1)'(dy);
		mul_a  = cmd.sq_y ? ay_q : ax_q;
		sum    = {1'b0, sqx_q} + {1'b0, prod_q};
		rem_sh = {rem_q[plac_pkg::REM_BITS-3:0], rad_q[plac_pkg::RAD_BITS-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_n  = ge ? rem_sh - trial : rem_sh;
		tsum   = {1'b0, total_q}
			+ {{(plac_pkg::TOTAL_BITS+1-plac_pkg::ROOT_BITS){1'b0}}, root_q};
		new_total = tsum[plac_pkg::TOTAL_BITS] ? '1 : tsum[plac_pkg::TOTAL_BITS-1:0];
	end

	assign sts.root_last = (cnt_q == plac_pkg::CNT_BITS'(plac_pkg::ROOT_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			total_q  <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd.load_in) begin
				last_x_q <= pos_x;
				last_y_q <= pos_y;
			end
			if (cmd.load_root) begin
				cnt_q <= '0;
			end else if (cmd.root_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				total_q <= new_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ax_q <= adx[plac_pkg::COORD_BITS-1:0];
			ay_q <= ady[plac_pkg::COORD_BITS-1:0];
		end
		if (cmd.sq_x || cmd.sq_y) begin
			prod_q <= mul_a * mul_a;
		end
		if (cmd.sq_y) begin
			sqx_q <= prod_q;
		end
		if (cmd.load_root) begin
			rad_q  <= {{(plac_pkg::RAD_BITS-plac_pkg::SUM_BITS){1'b0}}, sum};
			root_q <= '0;
			rem_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[plac_pkg::RAD_BITS-3:0], 2'b00};
			root_q <= {root_q[plac_pkg::ROOT_BITS-2:0], ge};
			rem_q  <= rem_n;
		end
		if (cmd.finish) begin
			seg_q     <= root_q;
			tot_out_q <= new_total;
			sat_q     <= &new_total;
		end
	end

	assign segment_length  = seg_q;
	assign total_length    = tot_out_q;
	assign total_saturated = sat_q;

endmodule

// ===== rtl/core/plac_ctrl.sv =====
`include "path_length_accumulator_top_macros.svh"

module plac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  plac_pkg::plac_sts_t sts,
	output plac_pkg::plac_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQX  = 5'b00010,
		ST_SQY  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_ROOT = 5'b10000
	} plac_state_t;

	plac_state_t state_q, state_n;
	logic        acc_q;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && !acc_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		state_n       = state_q;
		cmd.finish    = acc_q && slot_free;
		cmd.load_in   = in_valid && in_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load_in) begin
					state_n = ST_SQX;
				end
			end
			ST_SQX: begin
				cmd.sq_x = 1'b1;
				state_n  = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_n  = ST_ADD;
			end
			ST_ADD: begin
				cmd.load_root = 1'b1;
				state_n       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_last) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_ROOT && sts.root_last) begin
				acc_q <= 1'b1;
			end else if (cmd.finish) begin
				acc_q <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`PLA_ASSERT_NOW(a_finish_slot, cmd.finish, !out_valid_q || out_ready, "result overwrote word")
	`PLA_ASSERT_NEXT(a_accept_seq, in_valid && in_ready, state_q == ST_SQX, "accept did not start")
	`PLA_ASSERT_NEXT(a_root_hold, state_q == ST_ROOT && !sts.root_last, state_q == ST_ROOT,
		"root left early")
	`PLA_ASSERT_NEXT(a_finish_out, cmd.finish, out_valid_q && !acc_q, "finish lost")

endmodule

// ===== rtl/core/path_length_accumulator_top.sv =====
// An accepted word is squared (x, then y), summed and rooted, then waits in acc_q
// until the output register is free; no new word is taken before that. The 25-step
// restoring square root takes one radicand bit pair per cycle.
// A new word is taken while the previous result still waits in the output register.
// Reset (arst_n low): previous position (0,0), total zero, no result pending.
module path_length_accumulator_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [plac_pkg::COORD_BITS-1:0] pos_x,
	input  logic signed [plac_pkg::COORD_BITS-1:0] pos_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [plac_pkg::SEG_BITS-1:0]          segment_length,
	output logic [plac_pkg::TOTAL_BITS-1:0]        total_length,
	output logic                                   total_saturated
);

	plac_pkg::plac_cmd_t cmd;
	plac_pkg::plac_sts_t sts;

	plac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	plac_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.segment_length  (segment_length),
		.total_length    (total_length),
		.total_saturated (total_saturated)
	);

endmodule

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [plac_pkg::COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [plac_pkg::SEG_BITS-1:0]   seg;
		logic [plac_pkg::TOTAL_BITS-1:0] total;
		logic                            sat;
	} path_result_t;

	localparam coord_t COORD_MAX = {1'b0, {(plac_pkg::COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(plac_pkg::COORD_BITS-1){1'b0}}};
	localparam logic [plac_pkg::TOTAL_BITS-1:0] TOTAL_MAX = '1;
	localparam int                    RX_HOLD_CYCLES = 400;
	localparam int                    SETTLE_CYCLES  = 60;

	logic   clk       = 1'b0;
	logic   arst_n    = 1'b0;
	logic   in_valid  = 1'b0;
	logic   in_ready;
	coord_t pos_x     = '0;
	coord_t pos_y     = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	logic [plac_pkg::SEG_BITS-1:0]   segment_length;
	logic [plac_pkg::TOTAL_BITS-1:0] total_length;
	logic                            total_saturated;

	coord_t                          path_last_x;
	coord_t                          path_last_y;
	logic [plac_pkg::TOTAL_BITS-1:0] path_total;
	path_result_t                    path_expect_q[$];

	int send_idle_pct = 0;
	int rx_idle_pct   = 0;
	bit rx_hold_req   = 1'b0;
	int rx_hold_cnt   = 0;
	int mismatch_cnt  = 0;

	path_length_accumulator_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.segment_length  (segment_length),
		.total_length    (total_length),
		.total_saturated (total_saturated)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] trial;
		int          i;
		root = '0;
		rem  = '0;
		for (i = 31; i >= 0; i--) begin
			rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic void path_reset();
		path_last_x = '0;
		path_last_y = '0;
		path_total  = '0;
	endfunction

	// Predict one segment and advance the tracked position and total.
	function automatic void advance_path(input coord_t x, input coord_t y);
		longint       dx;
		longint       dy;
		logic [63:0]  sum_sq;
		logic [63:0]  acc;
		path_result_t r;
		dx = longint'(x) - longint'(path_last_x);
		dy = longint'(y) - longint'(path_last_y);
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		sum_sq = dx * dx + dy * dy;
		r.seg  = plac_pkg::SEG_BITS'(floor_sqrt(sum_sq));
		acc    = 64'(path_total) + 64'(r.seg);
		if (acc > 64'(TOTAL_MAX))
			acc = 64'(TOTAL_MAX);
		path_total  = acc[plac_pkg::TOTAL_BITS-1:0];
		r.total     = path_total;
		r.sat       = (path_total == TOTAL_MAX);
		path_last_x = x;
		path_last_y = y;
		path_expect_q.push_back(r);
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(3))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	function automatic coord_t pick_coord(input coord_t last);
		int d;
		d = int'($urandom_range(2048)) - 1024;
		case ($urandom_range(5))
			0, 1:    return coord_t'($urandom);
			2, 3:    return coord_t'(last + d);
			4:       return pick_extreme();
			default: return last;
		endcase
	endfunction

	task automatic send_word(input coord_t x, input coord_t y);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x    <= x;
		pos_y    <= y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_path(x, y);
	endtask

	// Drop valid and wait for every predicted word to come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (path_expect_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (rx_hold_cnt != 0) begin
			out_ready   <= 1'b0;
			rx_hold_cnt = rx_hold_cnt - 1;
		end else if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_cnt = RX_HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endfunction

	always @(posedge clk) begin : check_out
		path_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (path_expect_q.size() == 0) begin
				$error("unexpected word: segment_length %0d total_length %0d",
					segment_length, total_length);
				mismatch_cnt++;
			end else begin
				want = path_expect_q.pop_front();
				check_field("segment_length", want.seg, segment_length);
				check_field("total_length", want.total, total_length);
				check_field("total_saturated", want.sat, total_saturated);
			end
		end
	end

	task automatic test_from_reset();
		send_word('0, '0);
		send_word('0, '0);
		send_word(coord_t'(3 << 8), coord_t'(4 << 8));
		drain();
	endtask

	task automatic test_extremes();
		send_word(COORD_MAX, COORD_MAX);
		send_word(COORD_MIN, COORD_MIN);
		send_word(COORD_MAX, COORD_MAX);
		send_word(COORD_MIN, COORD_MAX);
		send_word(COORD_MAX, COORD_MIN);
		send_word(COORD_MAX, COORD_MIN);
		send_word('0, COORD_MAX);
		send_word('0, COORD_MIN);
		send_word(COORD_MIN, '0);
		send_word('1, '1);
		drain();
	endtask

	task automatic test_rounding();
		send_word('0, '0);
		send_word(coord_t'(1), coord_t'(1));
		send_word(coord_t'(2), coord_t'(3));
		send_word('1, '0);
		send_word('0, '1);
		send_word(coord_t'(-5), coord_t'(-12));
		send_word(coord_t'(1000), coord_t'(-777));
		drain();
	endtask

	task automatic test_random(input int count, input int tx_idle, input int rx_idle);
		coord_t x;
		coord_t y;
		send_idle_pct = tx_idle;
		rx_idle_pct   = rx_idle;
		repeat (count) begin
			x = pick_coord(path_last_x);
			y = pick_coord(path_last_y);
			send_word(x, y);
		end
		drain();
		send_idle_pct = 0;
		rx_idle_pct   = 0;
	endtask

	// Hold the receiver off long enough for the block to back up its input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		rx_idle_pct   = 0;
		rx_hold_req   = 1'b1;
		repeat (20)
			send_word(coord_t'($urandom), coord_t'($urandom));
		drain();
	endtask

	initial begin
		path_reset();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_from_reset();
		test_extremes();
		test_rounding();
		test_random(300, 30, 46);
		test_random(300, 46, 30);
		test_random(300, 0, 0);
		test_backpressure();

		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_cnt == 0 && path_expect_q.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/plac_pkg.sv
rtl/core/plac_dp.sv
rtl/core/plac_ctrl.sv
rtl/core/path_length_accumulator_top.sv
test/tb_top.sv
